/* hw/rtl/a2u_pkg.sv */
`timescale 1ns / 1ps

package a2u_pkg;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_X  = 8'h78;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7a;

   localparam logic [7:0] LETTER_BASE = 8'd10;

   localparam logic [5:0] RADIX_AUTO  = 6'd0;
   localparam logic [5:0] RADIX_OCTAL = 6'd8;
   localparam logic [5:0] RADIX_DEC   = 6'd10;
   localparam logic [5:0] RADIX_HEX   = 6'd16;

   typedef struct packed {
      logic       start;
      logic       blank;
      logic       minus;
      logic       plus;
      logic       zero;
      logic       hex_x;
      logic       alnum;
      logic [5:0] dval;
   } a2u_class_type;

endpackage

/* hw/rtl/ascii_to_unsigned_parser.sv */
`timescale 1ns / 1ps

// Streaming string-to-unsigned converter, one character per request.
// The req channel carries a character in req_tdata and a start-of-string
// flag in req_tuser, which abandons any parse in progress. A string ends at
// NUL or at any character that cannot continue the number; that character
// produces exactly one response, and later characters are ignored until the
// next start flag. Leading whitespace and one sign are skipped, and with a
// base of zero the radix comes from the prefix (octal, hex or decimal).
// The csr channel writes the base; the user must write it only while the
// block idles; the block itself does not enforce it. A request passes the
// classifier into a four-entry queue, the parser takes it from the head, and
// the response is registered. The parser takes one character per cycle while
// no response waits, bounded by its multiply-add of accumulator and radix.
// Reset empties the queue, clears the parse and sets the base to zero.
// When the receiver stalls, the parser holds while a response waits; the
// queue absorbs up to four more requests before req_tready falls.

module ascii_to_unsigned_parser import a2u_pkg::*; #(
   parameter int OFFSET_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_code
   input  logic        req_tuser,   // start_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // value[31:0], end_offset[47:32]
   output logic        rsp_tuser,   // converted
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data     // base_mode
);

   logic [5:0]    base_mode_ff;
   logic          queue_full;
   logic          push;
   a2u_class_type push_item;
   logic          pop;
   logic          head_valid;
   a2u_class_type head_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_mode_ff <= RADIX_AUTO;
      end else if (csr_valid) begin
         base_mode_ff <= csr_data;
      end
   end

   a2u_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   a2u_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   a2u_back #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .base_mode  (base_mode_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* hw/rtl/a2u_front.sv */
`timescale 1ns / 1ps

module a2u_front import a2u_pkg::*; (
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,
   input  logic          req_tuser,
   input  logic          queue_full,
   output logic          push,
   output a2u_class_type push_item
);

   logic [7:0] code;
   logic [7:0] raw_val;

   assign code       = req_tdata;
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      raw_val = 8'd0;
      push_item.alnum = 1'b1;
      if (code inside {[CHAR_ZERO:CHAR_NINE]}) begin
         raw_val = code - CHAR_ZERO;
      end else if (code inside {[CHAR_LO_A:CHAR_LO_Z]}) begin
         raw_val = code - CHAR_LO_A + LETTER_BASE;
      end else if (code inside {[CHAR_UP_A:CHAR_UP_Z]}) begin
         raw_val = code - CHAR_UP_A + LETTER_BASE;
      end else begin
         push_item.alnum = 1'b0;
      end
      push_item.start = req_tuser;
      push_item.blank = code inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE};
      push_item.minus = code == CHAR_MINUS;
      push_item.plus  = code == CHAR_PLUS;
      push_item.zero  = code == CHAR_ZERO;
      push_item.hex_x = code == CHAR_LO_X || code == CHAR_UP_X;
      push_item.dval  = raw_val[5:0];
   end

endmodule

/* hw/rtl/a2u_queue.sv */
`timescale 1ns / 1ps

module a2u_queue import a2u_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  a2u_class_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output a2u_class_type head_item
);

   localparam int DEPTH = 4;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(DEPTH);

   a2u_class_type               store_ff [DEPTH];
   logic [PTR_BITS-1:0]         wr_ptr_ff;
   logic [PTR_BITS-1:0]         rd_ptr_ff;
   logic [CNT_BITS-1:0]         count_ff;
   logic [CNT_BITS-1:0]         count_in;

   assign full       = count_ff == DEPTH_CNT;
   assign head_valid = count_ff != '0;
   assign head_item  = store_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT) else $error("request queue count exceeds its depth");
   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("request queue popped while empty");
`endif

endmodule

/* hw/rtl/a2u_back.sv */
`timescale 1ns / 1ps

module a2u_back import a2u_pkg::*; #(
   parameter int OFFSET_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [5:0]    base_mode,
   input  logic          head_valid,
   input  a2u_class_type head_item,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [47:0]   rsp_tdata,
   output logic          rsp_tuser
);

   typedef enum logic [2:0] {
      PH_WS1,
      PH_WS2,
      PH_ZERO,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

   phase_type              phase_ff, phase_in, ph;
   logic [31:0]            acc_ff, acc_in, acc;
   logic                   neg_ff, neg_in, neg;
   logic [5:0]             radix_ff, radix_in, radix;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in, pos;
   logic                   any_ff, any_in, any;
   logic                   first_char;
   logic                   use_dos;
   logic                   digit_ok;
   logic [37:0]            prod;
   logic                   emit;
   logic [31:0]            emit_value;
   logic [OFFSET_BITS+15:0] emit_pos_ext;
   logic                   rsp_valid_ff;
   logic [47:0]            rsp_data_ff;
   logic                   rsp_user_ff;

   assign pop        = head_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      ph    = head_item.start ? PH_WS1 : phase_ff;
      acc   = head_item.start ? 32'd0 : acc_ff;
      neg   = head_item.start ? 1'b0 : neg_ff;
      radix = head_item.start ? RADIX_AUTO : radix_ff;
      pos   = head_item.start ? '0 : pos_ff;
      any   = head_item.start ? 1'b0 : any_ff;

      phase_in   = ph;
      acc_in     = acc;
      neg_in     = neg;
      radix_in   = radix;
      any_in     = any;
      pos_in     = (pos != POS_MAX) ? pos + 1'b1 : pos;
      first_char = 1'b0;
      use_dos    = 1'b0;
      emit       = 1'b0;

      case (ph)
         PH_WS1: begin
            if (head_item.blank) begin
               phase_in = PH_WS1;
            end else if (head_item.minus) begin
               neg_in   = 1'b1;
               phase_in = PH_WS2;
            end else if (head_item.plus) begin
               phase_in = PH_WS2;
            end else begin
               first_char = 1'b1;
            end
         end
         PH_WS2: begin
            if (!head_item.blank) begin
               first_char = 1'b1;
            end
         end
         PH_ZERO: begin
            if (head_item.hex_x && (radix == RADIX_AUTO || radix == RADIX_HEX)) begin
               any_in   = 1'b0;
               radix_in = RADIX_HEX;
               phase_in = PH_DIGITS;
            end else begin
               radix_in = (radix == RADIX_AUTO) ? RADIX_OCTAL : radix;
               use_dos  = 1'b1;
            end
         end
         PH_DIGITS: begin
            use_dos = 1'b1;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      if (first_char) begin
         if (head_item.zero) begin
            radix_in = base_mode;
            any_in   = 1'b1;
            phase_in = PH_ZERO;
         end else begin
            radix_in = (base_mode == RADIX_AUTO) ? RADIX_DEC : base_mode;
            use_dos  = 1'b1;
         end
      end

      digit_ok = head_item.alnum && (head_item.dval < radix_in);
      prod     = acc * radix_in;
      if (use_dos) begin
         if (digit_ok) begin
            any_in   = 1'b1;
            acc_in   = prod[31:0] + {26'd0, head_item.dval};
            phase_in = PH_DIGITS;
         end else begin
            emit     = 1'b1;
            phase_in = PH_DONE;
         end
      end

      emit_value   = neg ? (32'd0 - acc) : acc;
      emit_pos_ext = {16'd0, (any_in ? pos : {OFFSET_BITS{1'b0}})};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WS1;
         acc_ff       <= 32'd0;
         neg_ff       <= 1'b0;
         radix_ff     <= RADIX_AUTO;
         pos_ff       <= '0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= 48'd0;
         rsp_user_ff  <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            radix_ff <= radix_in;
            pos_ff   <= pos_in;
            any_ff   <= any_in;
         end
         if (pop && emit) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= {emit_pos_ext[15:0], emit_value};
            rsp_user_ff  <= any_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef ASSERT_OFF
   a_emit_done : assert property (@(posedge clock) disable iff (reset)
      (pop && emit) |=> (phase_ff == PH_DONE && rsp_valid_ff))
      else $error("result issued without ending the parse");
   a_unconverted_offset : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_user_ff) |-> (rsp_data_ff[47:32] == 16'd0))
      else $error("non-zero offset on an unconverted result");
`endif

endmodule

/* verif/tb_ascii_to_unsigned_parser.sv */
`timescale 1ns / 1ps

module tb_ascii_to_unsigned_parser;
   import a2u_pkg::*;

   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          DRAIN_CYCLES = 12;
   localparam int          HOLD_CYCLES  = 250;
   localparam logic [15:0] OFFSET_MAX   = 16'hffff;

   typedef enum logic [2:0] {
      LEAD_BLANKS, SIGN_BLANKS, LEAD_ZERO, DIGITS, DONE
   } parse_state_type;

   typedef struct packed {
      logic [31:0] value;
      logic [15:0] end_offset;
      logic        converted;
   } conv_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_data   = 6'd0;

   parse_state_type parse_state;
   logic [31:0]  accum;
   logic         minus_seen;
   logic [5:0]   radix_in_use;
   logic [15:0]  char_count;
   logic         digit_seen;
   logic [5:0]   base_setting;

   conv_result_type expected_results[$];
   conv_result_type want, got;

   int errors          = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int base_writes     = 0;
   int cycle_count     = 0;
   int idle_pct        = 0;
   int stall_pct       = 0;
   int hold_seq        = 0;
   int hold_seen       = 0;
   int hold_left       = 0;

   ascii_to_unsigned_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // The receiver stalls at random, and holds off completely for a long stretch on request.
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen  <= hold_seq;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value      = rsp_tdata[31:0];
         got.end_offset = rsp_tdata[47:32];
         got.converted  = rsp_tuser;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: response with none expected: value %h, offset %0d, converted %b",
                     $time, got.value, got.end_offset, got.converted);
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (got.value !== want.value) begin
               errors++;
               $display("%0t: value expected %h, actual %h", $time, want.value, got.value);
            end
            if (got.end_offset !== want.end_offset) begin
               errors++;
               $display("%0t: end_offset expected %0d, actual %0d",
                        $time, want.end_offset, got.end_offset);
            end
            if (got.converted !== want.converted) begin
               errors++;
               $display("%0t: converted expected %b, actual %b",
                        $time, want.converted, got.converted);
            end
         end
      end
   end

   function automatic bit is_blank(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic int digit_of(input logic [7:0] c, input logic [5:0] radix);
      int v;
      if (c >= CHAR_ZERO && c <= CHAR_NINE)
         v = int'(c - CHAR_ZERO);
      else if (c >= CHAR_LO_A && c <= CHAR_LO_Z)
         v = int'(c - CHAR_LO_A) + int'(LETTER_BASE);
      else if (c >= CHAR_UP_A && c <= CHAR_UP_Z)
         v = int'(c - CHAR_UP_A) + int'(LETTER_BASE);
      else
         return -1;
      return (v < int'(radix)) ? v : -1;
   endfunction

   function automatic void clear_parse();
      parse_state  = LEAD_BLANKS;
      accum        = 32'd0;
      minus_seen   = 1'b0;
      radix_in_use = RADIX_AUTO;
      char_count   = 16'd0;
      digit_seen   = 1'b0;
   endfunction

   function automatic bit digit_or_stop(input logic [7:0] c, input logic [15:0] pos,
                                        output conv_result_type r);
      int d;
      d = digit_of(c, radix_in_use);
      r = '0;
      if (d >= 0) begin
         digit_seen  = 1'b1;
         accum       = accum * radix_in_use + 32'(d);
         parse_state = DIGITS;
         return 1'b0;
      end
      r.value      = minus_seen ? 32'd0 - accum : accum;
      r.end_offset = digit_seen ? pos : 16'd0;
      r.converted  = digit_seen;
      parse_state  = DONE;
      return 1'b1;
   endfunction

   function automatic bit start_number(input logic [7:0] c, input logic [15:0] pos,
                                       output conv_result_type r);
      r = '0;
      parse_state  = SIGN_BLANKS;
      radix_in_use = base_setting;
      if (c == CHAR_ZERO) begin
         digit_seen  = 1'b1;
         parse_state = LEAD_ZERO;
         return 1'b0;
      end
      if (radix_in_use == RADIX_AUTO)
         radix_in_use = RADIX_DEC;
      return digit_or_stop(c, pos, r);
   endfunction

   function automatic bit parse_char(input logic sos, input logic [7:0] c,
                                     output conv_result_type r);
      logic [15:0] pos;
      r = '0;
      if (sos)
         clear_parse();
      pos = char_count;
      if (char_count != OFFSET_MAX)
         char_count++;
      case (parse_state)
         LEAD_BLANKS: begin
            if (is_blank(c))
               return 1'b0;
            if (c == CHAR_MINUS) begin
               minus_seen  = 1'b1;
               parse_state = SIGN_BLANKS;
               return 1'b0;
            end
            if (c == CHAR_PLUS) begin
               parse_state = SIGN_BLANKS;
               return 1'b0;
            end
            return start_number(c, pos, r);
         end
         SIGN_BLANKS: begin
            if (is_blank(c))
               return 1'b0;
            return start_number(c, pos, r);
         end
         LEAD_ZERO: begin
            if ((c == CHAR_LO_X || c == CHAR_UP_X) &&
                (radix_in_use == RADIX_AUTO || radix_in_use == RADIX_HEX)) begin
               digit_seen   = 1'b0;
               radix_in_use = RADIX_HEX;
               parse_state  = DIGITS;
               return 1'b0;
            end
            if (radix_in_use == RADIX_AUTO)
               radix_in_use = RADIX_OCTAL;
            return digit_or_stop(c, pos, r);
         end
         DIGITS: return digit_or_stop(c, pos, r);
         default: return 1'b0;
      endcase
   endfunction

   task automatic send_item(input logic sos, input logic [7:0] c);
      conv_result_type r;
      req_tvalid <= 1'b1;
      req_tuser  <= sos;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (parse_char(sos, c, r))
         expected_results.push_back(r);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s, input bit with_start, input bit add_nul);
      int i;
      for (i = 0; i < s.len(); i++)
         send_item(with_start && i == 0, s[i]);
      if (add_nul)
         send_item(1'b0, CHAR_NUL);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_base(input logic [5:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      base_setting  = v;
      base_writes++;
   endtask

   function automatic logic [7:0] random_blank();
      int k;
      k = $urandom_range(0, 5);
      return (k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k);
   endfunction

   function automatic logic [7:0] digit_char(input logic [5:0] radix);
      int limit, d;
      limit = (radix > 36) ? 36 : int'(radix);
      d = $urandom_range(0, limit - 1);
      if (d < 10)
         return CHAR_ZERO + 8'(d);
      return ($urandom_range(0, 1) ? CHAR_UP_A : CHAR_LO_A) + 8'(d - 10);
   endfunction

   function automatic logic [5:0] pick_base();
      case ($urandom_range(0, 9))
         0, 1, 2: return RADIX_AUTO;
         3:       return RADIX_DEC;
         4:       return RADIX_HEX;
         5:       return RADIX_OCTAL;
         6:       return 6'd1;
         7:       return 6'd36;
         8:       return 6'd63;
         default: return 6'($urandom_range(0, 63));
      endcase
   endfunction

   // Mostly well-formed numbers with random content; the rest is noise, truncated strings
   // and strings without a start mark.
   task automatic send_random_string();
      logic [7:0] text[$];
      logic [5:0] eff;
      bit         mark;
      int         i, n, k;
      k = $urandom_range(0, 99);
      if (k < 12) begin
         n = $urandom_range(1, 8);
         for (i = 0; i < n; i++)
            send_item($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
         return;
      end
      mark = ($urandom_range(0, 19) != 0);
      repeat ($urandom_range(0, 2)) text.push_back(random_blank());
      k = $urandom_range(0, 2);
      if (k == 1)
         text.push_back(CHAR_MINUS);
      else if (k == 2)
         text.push_back(CHAR_PLUS);
      if (k != 0 && $urandom_range(0, 3) == 0)
         text.push_back(random_blank());
      eff = base_setting;
      if (base_setting == RADIX_AUTO) begin
         k = $urandom_range(0, 2);
         eff = RADIX_DEC;
         if (k >= 1) begin
            text.push_back(CHAR_ZERO);
            eff = RADIX_OCTAL;
         end
         if (k == 2) begin
            text.push_back($urandom_range(0, 1) ? CHAR_LO_X : CHAR_UP_X);
            eff = RADIX_HEX;
         end
      end else if (base_setting == RADIX_HEX && $urandom_range(0, 1)) begin
         text.push_back(CHAR_ZERO);
         text.push_back($urandom_range(0, 1) ? CHAR_LO_X : CHAR_UP_X);
      end
      repeat ($urandom_range(0, 12)) text.push_back(digit_char(eff));
      k = $urandom_range(0, 9);
      if (k < 7)
         text.push_back(CHAR_NUL);
      else if (k < 9)
         text.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 6) == 0)
         repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
      for (i = 0; i < text.size(); i++)
         send_item(mark && i == 0, text[i]);
   endtask

   task automatic test_directed_auto();
      idle_pct  = 0;
      stall_pct = 0;
      send_text("\t-7z", 1'b0, 1'b0);
      send_text(" 0x1F", 1'b1, 1'b1);
      send_text("0xg", 1'b1, 1'b0);
      send_text("017", 1'b1, 1'b1);
      send_text("+ ", 1'b1, 1'b0);
      send_item(1'b0, 8'hff);
      send_text("12", 1'b1, 1'b0);
      send_text("-0X10", 1'b1, 1'b1);
      send_text("ab", 1'b0, 1'b0);
      send_item(1'b1, CHAR_NUL);
      wait_drained();
   endtask

   task automatic test_radix_settings();
      write_base(RADIX_HEX);
      send_text("0XfF", 1'b1, 1'b1);
      send_text("0x", 1'b1, 1'b1);
      write_base(RADIX_OCTAL);
      send_text("0x7", 1'b1, 1'b1);
      write_base(6'd1);
      send_text("01", 1'b1, 1'b1);
      send_text("1", 1'b1, 1'b1);
      write_base(6'd36);
      send_text("-Zz", 1'b1, 1'b1);
      send_text("0x", 1'b1, 1'b1);
      write_base(6'd63);
      send_text("zZ~", 1'b1, 1'b0);
      write_base(6'd2);
      send_text("1012", 1'b1, 1'b1);
      write_base(RADIX_DEC);
      send_text("- \r5", 1'b1, 1'b1);
      wait_drained();
   endtask

   task automatic test_backpressure();
      int i;
      idle_pct  = 0;
      stall_pct = 0;
      write_base(RADIX_AUTO);
      hold_seq <= hold_seq + 1;
      for (i = 0; i < 40; i++)
         send_text("7", 1'b1, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int idle, input int stall, input int count);
      int target, chunk_end;
      idle_pct  = idle;
      stall_pct = stall;
      target    = items_sent + count;
      while (items_sent < target) begin
         write_base(pick_base());
         chunk_end = items_sent + 100;
         while (items_sent < chunk_end && items_sent < target)
            send_random_string();
      end
      wait_drained();
   endtask

   initial begin
      clear_parse();
      base_setting = RADIX_AUTO;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_auto();
      test_radix_settings();
      test_backpressure();
      test_random_traffic(0, 0, 450);
      test_random_traffic(49, 0, 450);
      test_random_traffic(0, 49, 450);
      test_random_traffic(23, 23, 450);

      wait_drained();
      $display("Sent %0d characters and checked %0d responses over %0d base settings.",
               items_sent, results_checked, base_writes);
      $display("Covered prefixes, signs, odd radices, restarts, idle gaps and long stalls.");
      if (errors == 0 && expected_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/a2u_pkg.sv
hw/rtl/a2u_front.sv
hw/rtl/a2u_queue.sv
hw/rtl/a2u_back.sv
hw/rtl/ascii_to_unsigned_parser.sv
verif/tb_ascii_to_unsigned_parser.sv
